// ----- sv/fnv_hash_table_linear_probe_core_defines.svh -----
// assertion macros shared by the core
`ifndef FNV_HASH_TABLE_LINEAR_PROBE_CORE_DEFINES_SVH
`define FNV_HASH_TABLE_LINEAR_PROBE_CORE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define FNVHT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define FNVHT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/fnvht_pkg.sv -----
package fnvht_pkg;

  localparam logic [31:0] FNV_BASIS = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME = 32'd16777619;
  localparam logic [7:0]  KEY_STOP  = 8'h3D;

  // job queue geometry
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = 1;
  localparam int unsigned QCNT_W = 2;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_LOOKUP = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_FOUND     = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_FULL      = 3'd3,
    ST_CLEARED   = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    BK_INIT,
    BK_IDLE,
    BK_MOD,
    BK_READ,
    BK_CHECK,
    BK_CLEAR,
    BK_RESP
  } bk_state_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  key_byte;
    logic        key_last;
    logic [15:0] value_handle;
  } in_item_t;

  typedef struct packed {
    status_e     status;
    logic [15:0] found_handle;
    logic [9:0]  slot_index;
  } out_item_t;

  // one finished key handed from front to back
  typedef struct packed {
    cmd_e        command;
    logic [31:0] hash;
    logic [15:0] handle;
  } job_t;

  typedef struct packed {
    logic init_busy;
    logic res_valid;
  } bk_stat_t;

endpackage

// ----- sv/fnvht_front.sv -----
module fnvht_front import fnvht_pkg::*; #(
  parameter int unsigned HANDLE_BITS = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     accept_i,
  input  in_item_t item_i,
  output logic     push_o,
  output job_t     job_o
);

  localparam int unsigned HB = (HANDLE_BITS < 16) ? HANDLE_BITS : 16;
  localparam logic [15:0] HMASK = 16'((33'd1 << HB) - 33'd1);

  logic [31:0] hash_q, hash_d, hash_upd;
  logic        stop_q, stop_d, stop_hit;
  logic        cmd_ok;

  always_comb begin
    stop_hit = !stop_q && (item_i.key_byte == KEY_STOP);
    hash_upd = hash_q;
    if (!stop_q && !stop_hit) begin
      hash_upd = (hash_q ^ {24'd0, item_i.key_byte}) * FNV_PRIME;
    end
    hash_d = hash_q;
    stop_d = stop_q;
    if (accept_i) begin
      if (item_i.key_last) begin
        hash_d = FNV_BASIS;
        stop_d = 1'b0;
      end else begin
        hash_d = hash_upd;
        stop_d = stop_q | stop_hit;
      end
    end
  end

  // the unused command code ends the key without a job
  assign cmd_ok = (item_i.command == CMD_INSERT) || (item_i.command == CMD_LOOKUP) ||
                  (item_i.command == CMD_CLEAR);

  assign push_o        = accept_i && item_i.key_last && cmd_ok;
  assign job_o.command = cmd_e'(item_i.command);
  assign job_o.hash    = hash_upd;
  assign job_o.handle  = item_i.value_handle & HMASK;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q <= FNV_BASIS;
      stop_q <= 1'b0;
    end else begin
      hash_q <= hash_d;
      stop_q <= stop_d;
    end
  end

endmodule

// ----- sv/fnvht_queue.sv -----
module fnvht_queue import fnvht_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  input  logic pop_i,
  output job_t job_o,
  output logic empty_o,
  output logic full_o
);

  job_t              q_mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == QCNT_W'(QDEPTH));
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign job_o   = q_mem[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      q_mem[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ----- sv/fnvht_back.sv -----
module fnvht_back import fnvht_pkg::*; #(
  parameter int unsigned MAX_SLOTS   = 1024,
  parameter int unsigned HANDLE_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [$clog2(MAX_SLOTS+1)-1:0] n_i,
  input  logic                           q_empty_i,
  input  job_t                           q_job_i,
  output logic                           pop_o,
  input  logic                           res_ready_i,
  output out_item_t                      res_o,
  output bk_stat_t                       stat_o
);

  localparam int unsigned NW = $clog2(MAX_SLOTS + 1);
  localparam int unsigned AW = $clog2(MAX_SLOTS);
  localparam int unsigned HB = (HANDLE_BITS < 16) ? HANDLE_BITS : 16;

  typedef struct packed {
    logic          valid;
    logic [31:0]   hash;
    logic [HB-1:0] handle;
  } slot_t;

  slot_t slot_mem [MAX_SLOTS];
  slot_t rd_q, mem_wdata;
  logic  mem_we;
  logic [AW-1:0] mem_waddr;

  bk_state_e state_q, state_d;
  job_t      job_q, job_d;
  logic [31:0] sh_q, sh_d;
  logic [4:0]  bit_q, bit_d;
  logic [AW-1:0] rem_q, rem_d, rem_step;
  logic [AW-1:0] pos_q, pos_d, pos_next;
  logic [AW-1:0] sweep_q, sweep_d;
  logic [NW-1:0] probe_q, probe_d;
  logic [NW-1:0] count_q, count_d;
  out_item_t res_q, res_d;

  logic [AW:0] mod_t, n_ext, pos_inc;
  logic        mod_done, sweep_end, last_probe, tbl_full, hit;
  logic [31:0] pos32;

  always_comb begin
    n_ext      = (AW+1)'(n_i);
    mod_t      = {rem_q, sh_q[31]};
    rem_step   = (mod_t >= n_ext) ? AW'(mod_t - n_ext) : mod_t[AW-1:0];
    mod_done   = (bit_q == 5'd31);
    pos_inc    = {1'b0, pos_q} + 1'b1;
    pos_next   = (pos_inc == n_ext) ? '0 : pos_inc[AW-1:0];
    sweep_end  = (sweep_q == AW'(MAX_SLOTS - 1));
    last_probe = ((probe_q + 1'b1) == n_i);
    tbl_full   = (count_q >= (n_i - 1'b1));
    hit        = rd_q.valid && (rd_q.hash == job_q.hash);
    pos32      = 32'(pos_q);
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_INIT: begin
        if (sweep_end) state_d = BK_IDLE;
      end
      BK_IDLE: begin
        if (!q_empty_i) begin
          state_d = (q_job_i.command == CMD_CLEAR) ? BK_CLEAR : BK_MOD;
        end
      end
      BK_MOD: begin
        if (mod_done) begin
          state_d = ((job_q.command == CMD_INSERT) && tbl_full) ? BK_RESP : BK_READ;
        end
      end
      BK_READ: state_d = BK_CHECK;
      BK_CHECK: begin
        case (job_q.command)
          CMD_INSERT: state_d = (!rd_q.valid || last_probe) ? BK_RESP : BK_READ;
          CMD_LOOKUP: state_d = (!rd_q.valid || hit || last_probe) ? BK_RESP : BK_READ;
          default:    state_d = BK_RESP;
        endcase
      end
      BK_CLEAR: begin
        if (sweep_end) state_d = BK_RESP;
      end
      BK_RESP: begin
        if (res_ready_i) state_d = BK_IDLE;
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    job_d     = job_q;
    sh_d      = sh_q;
    bit_d     = bit_q;
    rem_d     = rem_q;
    pos_d     = pos_q;
    sweep_d   = sweep_q;
    probe_d   = probe_q;
    count_d   = count_q;
    res_d     = res_q;
    pop_o     = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = sweep_q;
    mem_wdata = '0;
    case (state_q)
      BK_INIT: begin
        mem_we  = 1'b1;
        sweep_d = sweep_q + 1'b1;
      end
      BK_IDLE: begin
        if (!q_empty_i) begin
          pop_o   = 1'b1;
          job_d   = q_job_i;
          sh_d    = q_job_i.hash;
          bit_d   = '0;
          rem_d   = '0;
          sweep_d = '0;
        end
      end
      BK_MOD: begin
        rem_d = rem_step;
        sh_d  = {sh_q[30:0], 1'b0};
        bit_d = bit_q + 1'b1;
        if (mod_done) begin
          pos_d   = rem_step;
          probe_d = '0;
          res_d   = '{status: ST_FULL, found_handle: '0, slot_index: '0};
        end
      end
      BK_READ: ;
      BK_CHECK: begin
        pos_d   = pos_next;
        probe_d = probe_q + 1'b1;
        case (job_q.command)
          CMD_INSERT: begin
            if (!rd_q.valid) begin
              mem_we    = 1'b1;
              mem_waddr = pos_q;
              mem_wdata = '{valid: 1'b1, hash: job_q.hash, handle: job_q.handle[HB-1:0]};
              count_d   = count_q + 1'b1;
              res_d     = '{status: ST_INSERTED, found_handle: '0,
                            slot_index: pos32[9:0]};
            end else begin
              res_d = '{status: ST_FULL, found_handle: '0, slot_index: '0};
            end
          end
          CMD_LOOKUP: begin
            if (hit) begin
              res_d = '{status: ST_FOUND, found_handle: 16'(rd_q.handle),
                        slot_index: pos32[9:0]};
            end else begin
              res_d = '{status: ST_NOT_FOUND, found_handle: '0, slot_index: '0};
            end
          end
          default: ;
        endcase
      end
      BK_CLEAR: begin
        mem_we  = 1'b1;
        sweep_d = sweep_q + 1'b1;
        count_d = '0;
        res_d   = '{status: ST_CLEARED, found_handle: '0, slot_index: '0};
      end
      BK_RESP: ;
      default: ;
    endcase
  end

  assign res_o            = res_q;
  assign stat_o.init_busy = (state_q == BK_INIT);
  assign stat_o.res_valid = (state_q == BK_RESP);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      slot_mem[mem_waddr] <= mem_wdata;
    end
    rd_q <= slot_mem[pos_q];
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
    sh_q  <= sh_d;
    rem_q <= rem_d;
    pos_q <= pos_d;
    res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_INIT;
      bit_q   <= '0;
      sweep_q <= '0;
      probe_q <= '0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      bit_q   <= bit_d;
      sweep_q <= sweep_d;
      probe_q <= probe_d;
      count_q <= count_d;
    end
  end

endmodule

// ----- sv/fnv_hash_table_linear_probe_core.sv -----
// key bytes are hashed at one per cycle unless the input is stalled; a non-final byte
// gives no result; on the final byte of a key with a used command its job is queued;
// the back end pops it, reduces the hash mod slot count (one quotient bit per cycle),
// then probes (registered table read, then compare) and fills the output register
// (an insert into a full table skips the probes); a clear sweeps all MAX_SLOTS table
// entries, one per cycle, then reports; after reset the same sweep runs, input stalled
`include "fnv_hash_table_linear_probe_core_defines.svh"
module fnv_hash_table_linear_probe_core import fnvht_pkg::*; #(
  parameter int unsigned MAX_SLOTS   = 1024,
  parameter int unsigned HANDLE_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_item_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_item_o,
  input  logic        cfg_we_i,
  input  logic [10:0] cfg_wdata_i
);

  localparam int unsigned NW = $clog2(MAX_SLOTS + 1);
  // slot count after reset, held inside the supported range
  localparam int unsigned N_RESET = (MAX_SLOTS < 1024) ? MAX_SLOTS : 1024;

  // active slot count, clamped once when written
  logic [NW-1:0] n_q, n_d;
  logic [31:0]   cfg_wide;

  // front end
  logic in_accept;
  logic push;
  job_t push_job;

  // job queue
  logic q_empty, q_full, q_pop;
  job_t q_job;

  // back end and output register
  bk_stat_t  bk_stat;
  out_item_t bk_res;
  logic      res_ready;
  logic      out_valid_q;
  out_item_t out_q;

  // the queue must have room for a possible job, and the table sweep after reset
  // must be finished
  assign in_stall_o = q_full | bk_stat.init_busy;
  assign in_accept  = in_valid_i & ~in_stall_o;

  always_comb begin
    cfg_wide = 32'(cfg_wdata_i);
    n_d      = n_q;
    if (cfg_we_i) begin
      if (cfg_wide < 32'd2) begin
        n_d = NW'(2);
      end else if (cfg_wide > 32'(MAX_SLOTS)) begin
        n_d = NW'(MAX_SLOTS);
      end else begin
        n_d = NW'(cfg_wide);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q <= NW'(N_RESET);
    end else begin
      n_q <= n_d;
    end
  end

  // hash accumulation and job forming
  fnvht_front #(
    .HANDLE_BITS(HANDLE_BITS)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(in_accept),
    .item_i  (in_item_i),
    .push_o  (push),
    .job_o   (push_job)
  );

  // decouples byte intake from the probe engine
  fnvht_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (push_job),
    .pop_i  (q_pop),
    .job_o  (q_job),
    .empty_o(q_empty),
    .full_o (q_full)
  );

  // modulo, probing and table storage
  fnvht_back #(
    .MAX_SLOTS  (MAX_SLOTS),
    .HANDLE_BITS(HANDLE_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .n_i        (n_q),
    .q_empty_i  (q_empty),
    .q_job_i    (q_job),
    .pop_o      (q_pop),
    .res_ready_i(res_ready),
    .res_o      (bk_res),
    .stat_o     (bk_stat)
  );

  // output register; refills in the cycle it is drained
  assign res_ready = ~out_valid_q | ~out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= bk_stat.res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && bk_stat.res_valid) begin
      out_q <= bk_res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `FNVHT_ASSERT_IMPL(a_init_stalls, bk_stat.init_busy, in_stall_o,
    "input accepted during table sweep")
  `FNVHT_ASSERT_NEXT(a_res_lands, bk_stat.res_valid && res_ready, out_valid_o,
    "back-end result not captured in output register")
  `FNVHT_ASSERT_IMPL(a_miss_zero, out_valid_o && (out_item_o.status == ST_NOT_FOUND ||
    out_item_o.status == ST_FULL || out_item_o.status == ST_CLEARED),
    out_item_o.found_handle == '0 && out_item_o.slot_index == '0,
    "nonzero handle or slot on a result without a slot")
  `FNVHT_ASSERT_IMPL(a_ins_handle, out_valid_o && out_item_o.status == ST_INSERTED,
    out_item_o.found_handle == '0, "handle reported on insert")

endmodule

// ----- tb/fnv_hash_table_linear_probe_core_tb.sv -----
module fnv_hash_table_linear_probe_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fnvht_pkg::*;

  // block geometry, kept at the core's defaults
  localparam int unsigned SLOTS       = 1024;
  localparam int unsigned HANDLE_BITS = 16;

  // worst back-end job: modulo, a probe of every slot, output register
  localparam int unsigned SETTLE_CYC = 2 * SLOTS + 64;

  // command code the core leaves unused: restarts the hash, no item out
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // random part: one slot setting per phase
  localparam int NUM_PHASES = 10;
  localparam int PH_SLOTS [NUM_PHASES] = '{1024, 16, 4, 8, 4, 2, 1, 300, 2047, 37};
  localparam int PH_ITEMS [NUM_PHASES] = '{200, 150, 80, 80, 80, 80, 60, 200, 150, 120};
  localparam int PH_CLEAR [NUM_PHASES] = '{2, 3, 0, 0, 0, 5, 5, 2, 2, 4};

  // key text pool reused within a phase so that lookups hit and hashes repeat
  localparam int POOL_KEYS = 12;
  localparam int KEY_MAX   = 6;

  localparam int DIR_ROWS = 25;

  // directed row: either a slot count write or one input item
  typedef struct {
    bit          cfg;
    logic [10:0] cfg_val;
    in_item_t    item;
    bit          typed;
    out_item_t   res;
  } dir_row_t;

  // expected item typed into a directed row, handed to the monitor in order
  typedef struct {
    bit        typed;
    out_item_t res;
  } given_t;

  localparam out_item_t PREDICTED = '0;
  localparam in_item_t  NO_ITEM   = '0;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  in_item_t    in_item_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_item_t   out_item_o;
  logic        cfg_we_i = 1'b0;
  logic [10:0] cfg_wdata_i = '0;

  // shadow of the core: running hash, slot store and slot count
  logic [31:0] fnv_acc = FNV_BASIS;
  bit          hash_halted = 1'b0;
  bit          slot_used [SLOTS];
  logic [31:0] slot_key_hash [SLOTS];
  logic [15:0] slot_val [SLOTS];
  int unsigned used_count = 0;
  logic [10:0] slot_setting = 11'd1024;

  out_item_t   pending_outcomes [$];
  given_t      given_q [$];

  int          send_gap_pct = 0;
  int          recv_stall_pct = 0;
  int          items_sent = 0;
  int          items_taken = 0;
  int          results_seen = 0;
  int          cfg_writes = 0;
  int          mismatches = 0;
  int          status_seen [8];

  dir_row_t    dir_tab [DIR_ROWS];

  logic [7:0]  key_bytes [POOL_KEYS][KEY_MAX];
  int          key_len [POOL_KEYS];
  bit          key_stop [POOL_KEYS];

  fnv_hash_table_linear_probe_core #(
    .MAX_SLOTS  (SLOTS),
    .HANDLE_BITS(HANDLE_BITS)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // fold one key byte into the shadow hash; on the last byte run the command
  // returns 1 when the byte yields a result item
  function automatic bit slot_outcome(input in_item_t it, output out_item_t res);
    logic [31:0] h;
    int unsigned n;
    int unsigned pos;
    bit          hit;
    bit          stop;
    res = '0;
    if (!hash_halted) begin
      if (it.key_byte == KEY_STOP) begin
        hash_halted = 1'b1;
      end else begin
        fnv_acc = (fnv_acc ^ {24'd0, it.key_byte}) * FNV_PRIME;
      end
    end
    if (!it.key_last) return 1'b0;

    h = fnv_acc;
    fnv_acc = FNV_BASIS;
    hash_halted = 1'b0;
    // slot count is clamped to between 2 and the store size
    n = 32'(slot_setting);
    if (n < 2) n = 2;
    if (n > SLOTS) n = SLOTS;
    pos = h % n;
    hit = 1'b0;
    stop = 1'b0;

    case (it.command)
      CMD_INSERT: begin
        // one empty slot is always kept so lookups terminate
        if (used_count < n - 1) begin
          for (int unsigned i = 0; i < n && !hit; i++) begin
            if (!slot_used[pos]) begin
              slot_used[pos] = 1'b1;
              slot_key_hash[pos] = h;
              slot_val[pos] = it.value_handle;
              used_count++;
              hit = 1'b1;
            end else begin
              pos = (pos + 1 == n) ? 0 : pos + 1;
            end
          end
        end
        if (hit) begin
          res.status = ST_INSERTED;
          res.slot_index = 10'(pos);
        end else begin
          res.status = ST_FULL;
        end
      end
      CMD_LOOKUP: begin
        // first equal hash on the probe path wins, an empty slot ends it
        for (int unsigned i = 0; i < n && !stop; i++) begin
          if (!slot_used[pos]) begin
            stop = 1'b1;
          end else if (slot_key_hash[pos] == h) begin
            hit = 1'b1;
            stop = 1'b1;
          end else begin
            pos = (pos + 1 == n) ? 0 : pos + 1;
          end
        end
        if (hit) begin
          res.status = ST_FOUND;
          res.found_handle = slot_val[pos];
          res.slot_index = 10'(pos);
        end else begin
          res.status = ST_NOT_FOUND;
        end
      end
      CMD_CLEAR: begin
        foreach (slot_used[i]) slot_used[i] = 1'b0;
        used_count = 0;
        res.status = ST_CLEARED;
      end
      default: begin
        return 1'b0;
      end
    endcase
    return 1'b1;
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    it.command = 2'($urandom_range(3));
    it.key_byte = 8'($urandom_range(255));
    it.key_last = 1'($urandom_range(1));
    it.value_handle = 16'($urandom_range(65535));
    return it;
  endfunction

  // present one item, with random sender gaps, and hold it until taken
  task automatic send_item(input in_item_t it, input bit typed = 1'b0,
                           input out_item_t res = '0);
    given_t g;
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    g.typed = typed;
    g.res = res;
    given_q.push_back(g);
    in_valid_i <= 1'b1;
    in_item_i <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
  endtask

  // stop sending until every outstanding result item is back
  task automatic drain_outcomes();
    in_valid_i <= 1'b0;
    // let the monitor log the last accepted item first
    @(posedge clk_i);
    while (pending_outcomes.size() != 0) @(posedge clk_i);
  endtask

  // slot count write, only with the core idle
  task automatic write_slots(input logic [10:0] v);
    drain_outcomes();
    // settle for the worst back-end job before the write
    repeat (SETTLE_CYC) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // receiver side: random stall per cycle
  always @(posedge clk_i) begin
    out_stall_i <= rst_ni && ($urandom_range(99) < recv_stall_pct);
  end

  // monitor: shadow update on accepted input, compare on accepted output
  always @(posedge clk_i) begin : monitor
    out_item_t predicted;
    out_item_t want;
    given_t    g;
    bit        produced;
    if (rst_ni) begin
      if (cfg_we_i) begin
        slot_setting = cfg_wdata_i;
        cfg_writes++;
      end
      if (in_valid_i && !in_stall_o) begin
        produced = slot_outcome(in_item_i, predicted);
        g = given_q.pop_front();
        items_taken++;
        if (produced) pending_outcomes.push_back(g.typed ? g.res : predicted);
      end
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        status_seen[out_item_o.status]++;
        if (pending_outcomes.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: unexpected item: status %0d handle %h slot %0d", $time,
                     out_item_o.status, out_item_o.found_handle, out_item_o.slot_index);
          end
        end else begin
          want = pending_outcomes.pop_front();
          if (out_item_o.status !== want.status ||
              out_item_o.found_handle !== want.found_handle ||
              out_item_o.slot_index !== want.slot_index) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: expected status %0d handle %h slot %0d, got status %0d handle %h slot %0d",
                       $time, want.status, want.found_handle, want.slot_index,
                       out_item_o.status, out_item_o.found_handle, out_item_o.slot_index);
            end
          end
        end
      end
    end
  end

  // hang guard
  initial begin
    #200_000_000;
    $display("fnv_hash_table_linear_probe_core_tb failed");
    $finish;
  end

  initial begin : stimulus
    in_item_t    it;
    logic [1:0]  cmd;
    int          roll;
    int          k;
    int          total;
    int          phase_start;

    dir_tab = '{
      // empty store after reset
      '{0, 11'd0, '{CMD_LOOKUP, 8'h00, 1'b1, 16'h0000}, 1, '{ST_NOT_FOUND, 16'h0000, 10'd0}},
      '{0, 11'd0, '{CMD_INSERT, 8'hFF, 1'b1, 16'hFFFF}, 0, PREDICTED},
      '{0, 11'd0, '{CMD_LOOKUP, 8'hFF, 1'b1, 16'h0000}, 0, PREDICTED},
      // command on a non-final byte is ignored
      '{0, 11'd0, '{CMD_CLEAR,  8'h00, 1'b0, 16'hFFFF}, 0, PREDICTED},
      '{0, 11'd0, '{CMD_INSERT, 8'hFF, 1'b1, 16'h0000}, 0, PREDICTED},
      // same hash inserted again, lookup returns the first copy
      '{0, 11'd0, '{CMD_INSERT, 8'hFF, 1'b1, 16'h1234}, 0, PREDICTED},
      '{0, 11'd0, '{CMD_LOOKUP, 8'hFF, 1'b1, 16'hFFFF}, 0, PREDICTED},
      // bytes from the stop byte on do not change the hash
      '{0, 11'd0, '{CMD_UNUSED, 8'hFF, 1'b0, 16'h0000}, 0, PREDICTED},
      '{0, 11'd0, '{CMD_UNUSED, KEY_STOP, 1'b0, 16'h0000}, 0, PREDICTED},
      '{0, 11'd0, '{CMD_LOOKUP, 8'h41, 1'b1, 16'h0000}, 0, PREDICTED},
      // key of only the stop byte hashes to the basis
      '{0, 11'd0, '{CMD_INSERT, KEY_STOP, 1'b1, 16'h5A5A}, 0, PREDICTED},
      '{0, 11'd0, '{CMD_INSERT, KEY_STOP, 1'b0, 16'hA5A5}, 0, PREDICTED},
      '{0, 11'd0, '{CMD_LOOKUP, 8'h00, 1'b1, 16'h0000}, 0, PREDICTED},
      // unused command: no item, hash restarts
      '{0, 11'd0, '{CMD_UNUSED, 8'h55, 1'b1, 16'hFFFF}, 0, PREDICTED},
      '{0, 11'd0, '{CMD_LOOKUP, 8'hFF, 1'b1, 16'h0000}, 0, PREDICTED},
      '{0, 11'd0, '{CMD_CLEAR,  8'hAA, 1'b1, 16'h0000}, 1, '{ST_CLEARED, 16'h0000, 10'd0}},
      '{0, 11'd0, '{CMD_LOOKUP, 8'hFF, 1'b1, 16'h0000}, 1, '{ST_NOT_FOUND, 16'h0000, 10'd0}},
      // two slots: the second insert finds the store full
      '{1, 11'd2, NO_ITEM, 0, PREDICTED},
      '{0, 11'd0, '{CMD_INSERT, 8'h01, 1'b1, 16'h0001}, 0, PREDICTED},
      '{0, 11'd0, '{CMD_INSERT, 8'h02, 1'b1, 16'hFFFF}, 1, '{ST_FULL, 16'h0000, 10'd0}},
      // zero and all-ones slot counts clamp to the limits
      '{1, 11'd0, NO_ITEM, 0, PREDICTED},
      '{0, 11'd0, '{CMD_LOOKUP, 8'h01, 1'b1, 16'h0000}, 0, PREDICTED},
      '{1, 11'h7FF, NO_ITEM, 0, PREDICTED},
      '{0, 11'd0, '{CMD_LOOKUP, 8'h01, 1'b1, 16'h0000}, 0, PREDICTED},
      '{0, 11'd0, '{CMD_CLEAR,  8'h00, 1'b1, 16'hFFFF}, 1, '{ST_CLEARED, 16'h0000, 10'd0}}
    };

    // reset, then the core sweeps its store with the input stalled
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_gap_pct = 17;
    recv_stall_pct = 55;

    // directed part
    for (int r = 0; r < DIR_ROWS; r++) begin
      if (dir_tab[r].cfg) begin
        write_slots(dir_tab[r].cfg_val);
      end else begin
        send_item(dir_tab[r].item, dir_tab[r].typed, dir_tab[r].res);
      end
    end

    // random part: well-formed keys from a small pool, some noise items
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p < 4) begin
        send_gap_pct = 17;
        recv_stall_pct = 55;
      end else if (p < 7) begin
        send_gap_pct = 55;
        recv_stall_pct = 17;
      end else begin
        send_gap_pct = 0;
        recv_stall_pct = 0;
      end
      write_slots(11'(PH_SLOTS[p]));

      // fresh key pool, a stop byte now and then
      for (int q = 0; q < POOL_KEYS; q++) begin
        key_len[q] = $urandom_range(1, KEY_MAX);
        key_stop[q] = 1'b0;
        for (int j = 0; j < KEY_MAX; j++) begin
          if ($urandom_range(9) == 0) begin
            key_bytes[q][j] = KEY_STOP;
            if (j < key_len[q]) key_stop[q] = 1'b1;
          end else begin
            key_bytes[q][j] = 8'($urandom_range(255));
          end
        end
      end

      phase_start = items_sent;
      while (items_sent - phase_start < PH_ITEMS[p]) begin
        if ($urandom_range(99) < 8) begin
          // noise: any field value, breaks key sequences
          send_item(random_item());
        end else begin
          k = $urandom_range(POOL_KEYS - 1);
          roll = $urandom_range(99);
          if (roll < PH_CLEAR[p]) begin
            cmd = CMD_CLEAR;
          end else if (roll < PH_CLEAR[p] + 3) begin
            cmd = CMD_UNUSED;
          end else if ($urandom_range(1) == 1) begin
            cmd = CMD_INSERT;
          end else begin
            cmd = CMD_LOOKUP;
          end
          // ignored tail after a stop byte: different text, same hash
          total = key_len[k];
          if (key_stop[k] && $urandom_range(1) == 1) total += $urandom_range(1, 3);
          for (int j = 0; j < total; j++) begin
            it = random_item();
            if (j < key_len[k]) it.key_byte = key_bytes[k][j];
            it.key_last = (j == total - 1);
            if (it.key_last) it.command = cmd;
            send_item(it);
          end
          // occasional full drain between keys
          if ($urandom_range(49) == 0) drain_outcomes();
        end
      end
    end

    drain_outcomes();
    repeat (SETTLE_CYC) @(posedge clk_i);
    mismatches += pending_outcomes.size();

    $display("covered %0d items over %0d slot count writes, %0d results checked",
             items_taken, cfg_writes, results_seen);
    $display("  inserted %0d, found %0d, not found %0d, full %0d, cleared %0d",
             status_seen[ST_INSERTED], status_seen[ST_FOUND], status_seen[ST_NOT_FOUND],
             status_seen[ST_FULL], status_seen[ST_CLEARED]);
    if (mismatches == 0) begin
      $display("fnv_hash_table_linear_probe_core_tb passed");
    end else begin
      $display("fnv_hash_table_linear_probe_core_tb failed");
    end
    $finish;
  end

endmodule

// ----- fnv_hash_table_linear_probe_core.f -----
+incdir+sv
sv/fnvht_pkg.sv
sv/fnvht_front.sv
sv/fnvht_queue.sv
sv/fnvht_back.sv
sv/fnv_hash_table_linear_probe_core.sv
tb/fnv_hash_table_linear_probe_core_tb.sv
